// ===== rtl/klrs_pkg.sv =====
// Shared types and constants of the keyed log range sum block.
package klrs_pkg;

    localparam int YEAR_W   = 16;
    localparam int AMT_IN_W = 32;
    localparam int TOTAL_W  = 64;
    localparam int CAP_W    = 11;
    localparam int STAT_W   = 2;
    localparam int IN_TDATA_W = 48;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FWD  = 4'b0010,
        ST_BWD  = 4'b0100,
        ST_SUM  = 4'b1000
    } t_state;

endpackage

// ===== rtl/klrs_log_mem.sv =====
// Log storage: one write port, one read port with registered read data.
module klrs_log_mem
    import klrs_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/keyed_log_range_sum.sv =====
// Top level: append-only amount/year log with first-to-last year range sum.
//
//  channel   dir  handshake                 payload
//  s (items) in   i_s_tvalid / o_s_tready   tdata {year, amount}, tuser command
//  m (result)out  o_m_tvalid / i_m_tready   tdata total, tuser status
//  cfg       in   i_cfg_we                  i_cfg_wdata capacity_limit
//
//  An append answers in the cycle after its beat. A query scans forward to the first
//  match, back from the newest entry to the last match, then sums the entries from
//  first to last match; with no match it answers after the forward scan. The single
//  read port of the log memory paces the scans, one entry a cycle.
//  Reset (i_rst_n low, synchronous) empties the log and sets the capacity to 1024.
//  The result register lets a new item in while the previous result is taken in the
//  same cycle; a held result blocks the input side.
module keyed_log_range_sum
    import klrs_pkg::*;
#(
    parameter int LOG_DEPTH   = 1024,
    parameter int AMOUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,   // [31:0] amount, [47:32] year
    input  logic                  i_s_tuser,   // [0] command
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TOTAL_W-1:0]    o_m_tdata,   // [63:0] total
    output logic [STAT_W-1:0]     o_m_tuser,   // [1:0] status
    input  logic                  i_cfg_we,
    input  logic [CAP_W-1:0]      i_cfg_wdata
);

    localparam int IW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int SW = (AMOUNT_BITS < AMT_IN_W) ? AMOUNT_BITS : AMT_IN_W;
    localparam int MW = YEAR_W + SW;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CAP_W-1:0]    r_cap;
    logic [CW-1:0]       r_addr, n_addr;
    logic [IW-1:0]       r_paddr, n_paddr;
    logic                r_pv, n_pv;
    logic [IW-1:0]       r_first, n_first;
    logic [IW-1:0]       r_last, n_last;
    logic [YEAR_W-1:0]   r_key, n_key;
    logic [TOTAL_W-1:0]  r_sum, n_sum;
    logic                r_m_valid, n_m_valid;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [STAT_W-1:0]   r_status, n_status;

    logic                s_acc;
    logic                room;
    logic                mem_we;
    logic [MW-1:0]       mem_wdata;
    logic [MW-1:0]       mem_rdata;
    logic [YEAR_W-1:0]   rd_year;
    logic [SW-1:0]       rd_amt;
    logic                hit;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign room       = (32'(r_count) < 32'(r_cap)) && (32'(r_count) < 32'(LOG_DEPTH));
    assign mem_wdata  = {i_s_tdata[AMT_IN_W +: YEAR_W], i_s_tdata[SW-1:0]};
    assign rd_year    = mem_rdata[SW +: YEAR_W];
    assign rd_amt     = mem_rdata[SW-1:0];
    assign hit        = r_pv && (rd_year == r_key);

    klrs_log_mem #(
        .DEPTH  (LOG_DEPTH),
        .DATA_W (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_paddr   = r_paddr;
        n_pv      = 1'b0;
        n_first   = r_first;
        n_last    = r_last;
        n_key     = r_key;
        n_sum     = r_sum;
        n_m_valid = r_m_valid && !i_m_tready;
        n_total   = r_total;
        n_status  = r_status;
        mem_we    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == CMD_APPEND) begin
                        n_m_valid = 1'b1;
                        n_total   = '0;
                        if (room) begin
                            mem_we   = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_status = STAT_OK;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end else begin
                        n_key   = i_s_tdata[AMT_IN_W +: YEAR_W];
                        n_addr  = '0;
                        n_state = ST_FWD;
                    end
                end
            end
            ST_FWD: begin
                if (hit) begin
                    // first match found; scan back from the newest entry
                    n_first = r_paddr;
                    n_addr  = r_count - 1'b1;
                    n_state = ST_BWD;
                end else if (r_addr < r_count) begin
                    n_pv    = 1'b1;
                    n_paddr = r_addr[IW-1:0];
                    n_addr  = r_addr + 1'b1;
                end else if (!r_pv) begin
                    n_m_valid = 1'b1;
                    n_total   = '0;
                    n_status  = STAT_NOTFOUND;
                    n_state   = ST_IDLE;
                end
            end
            ST_BWD: begin
                // the entry at r_first matches, so this scan always stops
                if (hit) begin
                    n_last  = r_paddr;
                    n_addr  = CW'(r_first);
                    n_sum   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_pv    = 1'b1;
                    n_paddr = r_addr[IW-1:0];
                    n_addr  = r_addr - 1'b1;
                end
            end
            ST_SUM: begin
                if (r_pv) begin
                    n_sum = r_sum + TOTAL_W'(rd_amt);
                end
                if (r_addr <= CW'(r_last)) begin
                    n_pv    = 1'b1;
                    n_paddr = r_addr[IW-1:0];
                    n_addr  = r_addr + 1'b1;
                end else if (!r_pv) begin
                    n_m_valid = 1'b1;
                    n_total   = r_sum;
                    n_status  = STAT_OK;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cap     <= CAP_W'(1024);
            r_pv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_paddr  <= n_paddr;
        r_first  <= n_first;
        r_last   <= n_last;
        r_key    <= n_key;
        r_sum    <= n_sum;
        r_total  <= n_total;
        r_status <= n_status;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_total;
    assign o_m_tuser  = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(LOG_DEPTH))
        else $error("entry count above log depth");

    a_count_only_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(mem_we))
        else $error("entry count changed without an append");

    a_result_empty_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_m_valid)
        else $error("result held while a query runs");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_first <= r_last))
        else $error("sum range reversed");

    a_query_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && n_state == ST_IDLE) |=> o_m_tvalid)
        else $error("query finished without a result");

endmodule

// ===== verif/klrs_tb_pkg.sv =====
// Scoreboard for the keyed log range sum testbench: log mirror, expected answers, checks.
`timescale 1ns / 100ps
package klrs_tb_pkg;
    import klrs_pkg::*;

    localparam int LOG_ENTRIES = 1024;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [STAT_W-1:0]  status;
    } t_answer;

    class klrs_scoreboard;
        logic [AMT_IN_W-1:0] log_amount [LOG_ENTRIES];
        logic [YEAR_W-1:0]   log_year   [LOG_ENTRIES];
        int unsigned         entry_cnt;
        int unsigned         cap_limit;
        t_answer             pending_sums [$];
        int unsigned         fails;

        function new();
            entry_cnt = 0;
            cap_limit = 1024;
            fails     = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap_limit = value;
        endfunction

        function int unsigned stored();
            return entry_cnt;
        endfunction

        function int unsigned pending();
            return pending_sums.size();
        endfunction

        // Work out the answer of one accepted beat and queue it.
        function void accept_item(logic cmd, logic [AMT_IN_W-1:0] amount,
                                  logic [YEAR_W-1:0] year);
            t_answer     ans;
            int unsigned room;
            int unsigned first;
            int unsigned last;
            int unsigned idx;
            ans.total  = '0;
            ans.status = STAT_OK;
            room = (cap_limit > LOG_ENTRIES) ? LOG_ENTRIES : cap_limit;
            if (cmd == CMD_APPEND) begin
                if (entry_cnt >= room) begin
                    ans.status = STAT_FULL;
                end else begin
                    log_amount[entry_cnt] = amount;
                    log_year[entry_cnt]   = year;
                    entry_cnt++;
                end
            end else begin
                first = 0;
                while (first < entry_cnt && log_year[first] != year)
                    first++;
                if (first >= entry_cnt) begin
                    ans.status = STAT_NOTFOUND;
                end else begin
                    last = entry_cnt - 1;
                    while (last > first && log_year[last] != year)
                        last--;
                    // other-year entries between the two matches count too
                    for (idx = first; idx <= last; idx++)
                        ans.total += {{(TOTAL_W-AMT_IN_W){1'b0}}, log_amount[idx]};
                end
            end
            pending_sums.push_back(ans);
        endfunction

        task report(string what);
            fails++;
            $display("ERROR: %s", what);
        endtask

        task check_answer(logic [TOTAL_W-1:0] total, logic [STAT_W-1:0] status);
            t_answer want;
            if (pending_sums.size() == 0) begin
                report($sformatf("result total %h status %0d with nothing pending",
                                 total, status));
                return;
            end
            want = pending_sums.pop_front();
            if (total !== want.total)
                report($sformatf("total %h, expected %h", total, want.total));
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
        endtask
    endclass

endpackage

// ===== verif/tb.sv =====
// Top of the keyed log range sum testbench: clock, reset, stream drivers and stimulus.
`timescale 1ns / 100ps
module tb;
    import klrs_pkg::*;
    import klrs_tb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0] i_s_tdata   = '0;
    logic                  i_s_tuser   = CMD_APPEND;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [TOTAL_W-1:0]    o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;
    logic                  i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata = '0;

    int unsigned    tx_idle_pct  = 32;
    int unsigned    rx_idle_pct  = 73;
    int unsigned    hold_left    = 0;
    int unsigned    results_seen = 0;
    bit             held_once    = 1'b0;
    logic [YEAR_W-1:0] year_pool [8];
    klrs_scoreboard sb;

    keyed_log_range_sum #(
        .LOG_DEPTH   (1024),
        .AMOUNT_BITS (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [31:0] amount, [47:32] year
        .i_s_tuser   (i_s_tuser),   // [0] command
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [63:0] total
        .o_m_tuser   (o_m_tuser),   // [1:0] status
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #24_000_000;
        $display("keyed_log_range_sum test failed");
        $finish;
    end

    // Result side: check each beat, stall at random, hold off once for a long stretch.
    always @(posedge i_clk) begin
        if (i_rst_n && i_m_tready && o_m_tvalid) begin
            sb.check_answer(o_m_tdata, o_m_tuser);
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!held_once && results_seen >= 40) begin
            held_once = 1'b1;
            hold_left = 300;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(logic cmd, logic [AMT_IN_W-1:0] amount,
                             logic [YEAR_W-1:0] year);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {year, amount};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.accept_item(cmd, amount, year);
    endtask

    // Drop valid and hold until every queued answer has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() > 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(value);
    endtask

    task automatic random_phase(int unsigned items, int unsigned append_pct);
        logic                cmd;
        logic [AMT_IN_W-1:0] amount;
        logic [YEAR_W-1:0]   year;
        int unsigned         pause_at;
        pause_at = $urandom_range(items - 1);
        for (int unsigned k = 0; k < items; k++) begin
            cmd = ($urandom_range(99) < append_pct) ? CMD_APPEND : CMD_QUERY;
            case ($urandom_range(9))
                0:       amount = '1;
                1:       amount = $urandom_range(15);
                default: amount = $urandom();
            endcase
            // mostly years from a pool of eight so queries find ranges
            if ($urandom_range(99) < ((cmd == CMD_APPEND) ? 85 : 75))
                year = year_pool[$urandom_range(7)];
            else
                year = YEAR_W'($urandom());
            if (k == pause_at)
                drain();
            send_item(cmd, amount, year);
        end
        drain();
    endtask

    initial begin
        sb = new();
        year_pool[0] = '0;
        year_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            year_pool[i] = YEAR_W'($urandom());
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty log, then extremes of amount and year
        send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'h0000);
        send_item(CMD_QUERY,  32'h0000_0000, 16'hFFFF);
        send_item(CMD_APPEND, 32'hFFFF_FFFF, 16'h0000);
        send_item(CMD_APPEND, 32'h0000_0000, 16'hFFFF);
        send_item(CMD_APPEND, 32'hFFFF_FFFF, 16'h1234);
        send_item(CMD_APPEND, 32'h0000_0005, 16'h0000);
        send_item(CMD_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_QUERY,  32'h0000_0000, 16'h0000);
        send_item(CMD_QUERY,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_QUERY,  32'h0000_0000, 16'h1234);
        send_item(CMD_QUERY,  32'h0000_0000, 16'h0007);
        drain();
        // zero capacity rejects every append
        write_capacity(CAP_W'(0));
        send_item(CMD_APPEND, 32'h0000_0001, 16'h0001);
        send_item(CMD_QUERY,  32'h0000_0000, 16'h0000);
        drain();
        // capacity below the stored count keeps the entries
        write_capacity(CAP_W'(3));
        send_item(CMD_APPEND, 32'h8000_0000, 16'h1234);
        send_item(CMD_QUERY,  32'h0000_0000, 16'hFFFF);
        drain();
        write_capacity(CAP_W'(7));
        send_item(CMD_APPEND, 32'h0000_0010, 16'h1234);
        send_item(CMD_APPEND, 32'h0000_0020, 16'h0000);
        send_item(CMD_APPEND, 32'h0000_0040, 16'h0000);
        drain();
        // above the built depth
        write_capacity(11'h7FF);
        send_item(CMD_APPEND, 32'h0000_0080, 16'h0042);
        send_item(CMD_QUERY,  32'h0000_0000, 16'h1234);
        drain();

        write_capacity(CAP_W'(1024));
        random_phase(50, 50);
        write_capacity(11'h7FF);
        random_phase(45, 45);

        tx_idle_pct = 73;
        rx_idle_pct = 32;
        write_capacity(CAP_W'(sb.stored() + $urandom_range(3, 8)));
        random_phase(45, 80);
        write_capacity(CAP_W'(1));
        random_phase(40, 40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_capacity(CAP_W'($urandom_range(1024, sb.stored())));
        random_phase(50, 50);
        write_capacity(CAP_W'(0));
        random_phase(20, 30);
        write_capacity(CAP_W'(1024));
        random_phase(20, 50);

        repeat (2 * LOG_ENTRIES + 8) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("keyed_log_range_sum test passed");
        else
            $display("keyed_log_range_sum test failed");
        $finish;
    end

endmodule
